### sv/agsq_pkg.sv
// Package for the ack-gated send queue: default sizes, status and timer codes.
// No dependencies; imported by ack_gated_send_queue_unit and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package agsq_pkg;

    localparam int QUEUE_SLOTS_DEF = 256;
    localparam int MAX_BYTES_DEF   = 8;

    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_FULL     = 3'd2,
        ST_FAILED   = 3'd3,
        ST_NOTHING  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TM_LEAVE  = 2'd0,
        TM_ARM    = 2'd1,
        TM_DISARM = 2'd2
    } t_timer;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_ACK   = 1'b1
    } t_mode;

endpackage

`default_nettype wire

### sv/ack_gated_send_queue_unit.sv
// Ack-gated send queue: a stop-and-wait transmit queue with a ring buffer; depends on agsq_pkg.
// The result word is registered: it appears in the cycle after the input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the ring memory has one write and one read port.
// The head entry is prefetched into a register every cycle, with write bypass.
// Reset holds s_tready low and clears the pointers, the busy flag and the output valid flag;
// ring contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ack_gated_send_queue_unit
    import agsq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int MAX_BYTES   = MAX_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: msg_length[3:0], msg_data[67:4], link_accepts[68], zero pad.
    input  wire logic [71:0] s_tdata,
    // Fields from bit 0: mode.
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: status[2:0], send_valid[3], send_length[7:4],
    // send_data[71:8], timer_action[73:72], link_busy[74], zero pad.
    output logic [79:0]      m_tdata
);

    localparam int PTR_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int SLOT_W = MAX_BYTES * 8;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_SLOTS - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    logic [SLOT_W-1:0] r_mem_data [QUEUE_SLOTS];
    logic [LEN_W-1:0]  r_mem_len  [QUEUE_SLOTS];

    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic              r_busy, n_busy;
    logic [SLOT_W-1:0] r_head_data;
    logic [LEN_W-1:0]  r_head_len;

    logic              r_out_valid;
    logic [79:0]       r_out_data;

    logic              accept;
    t_mode             in_mode;
    logic [LEN_W-1:0]  in_len;
    logic [DATA_W-1:0] in_data;
    logic              in_accepts;
    logic [DATA_W-1:0] masked_data;

    t_status           status;
    logic              send_valid;
    logic [LEN_W-1:0]  send_len;
    logic [DATA_W-1:0] send_data;
    t_timer            timer;
    logic              wr_en;

    logic [PTR_W-1:0]  rd_eff;
    logic [PTR_W-1:0]  head_addr;

    assign s_tready   = i_rst_n && (!r_out_valid || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign in_mode    = t_mode'(s_tuser);
    assign in_len     = s_tdata[3:0];
    assign in_data    = s_tdata[67:4];
    assign in_accepts = s_tdata[68];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked_data[i*8 +: 8] = (LEN_W'(i) < in_len) ? in_data[i*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        status     = ST_OK;
        send_valid = 1'b0;
        send_len   = '0;
        send_data  = '0;
        timer      = TM_LEAVE;
        wr_en      = 1'b0;
        n_busy     = r_busy;
        n_rd       = r_rd;
        n_wr       = r_wr;
        unique case (in_mode)
            MODE_WRITE: begin
                if (in_len > LEN_W'(MAX_BYTES)) begin
                    status = ST_TOO_LONG;
                end else if (r_busy) begin
                    if (ring_next(r_wr) == r_rd) begin
                        status = ST_FULL;
                    end else begin
                        wr_en = 1'b1;
                        n_wr  = ring_next(r_wr);
                    end
                end else if (in_accepts) begin
                    n_busy     = 1'b1;
                    send_valid = 1'b1;
                    send_len   = in_len;
                    send_data  = masked_data;
                    timer      = TM_ARM;
                end else begin
                    n_busy = 1'b0;
                    timer  = TM_DISARM;
                    status = ST_FAILED;
                end
            end
            MODE_ACK: begin
                if (!r_busy) begin
                    status = ST_NOTHING;
                end else if (r_rd == r_wr) begin
                    n_busy = 1'b0;
                    timer  = TM_DISARM;
                end else if (in_accepts) begin
                    send_valid = 1'b1;
                    send_len   = r_head_len;
                    send_data  = DATA_W'(r_head_data);
                    n_rd       = ring_next(r_rd);
                end else begin
                    status = ST_FAILED;
                    timer  = TM_ARM;
                end
            end
            default: begin
                status = ST_NOTHING;
            end
        endcase
    end

    assign rd_eff    = accept ? n_rd : r_rd;
    assign head_addr = ring_next(rd_eff);

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem_data[n_wr] <= masked_data[SLOT_W-1:0];
            r_mem_len[n_wr]  <= in_len;
        end
        if (accept && wr_en && (n_wr == head_addr)) begin
            r_head_data <= masked_data[SLOT_W-1:0];
            r_head_len  <= in_len;
        end else begin
            r_head_data <= r_mem_data[head_addr];
            r_head_len  <= r_mem_len[head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_wr        <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_rd        <= n_rd;
                r_wr        <= n_wr;
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {5'b0, n_busy, timer, send_data, send_len, send_valid, status};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_rd == r_wr))
        else $error("ring holds entries while the link is idle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");

    a_queue_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wr_en) |=> r_busy)
        else $error("entry queued while the link is idle");

    a_head_moves_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_mode == MODE_ACK && send_valid) |=> (r_rd != $past(r_rd)))
        else $error("queued send did not advance the read pointer");

endmodule

`default_nettype wire

### tb/ack_gated_send_queue_unit_tb.sv
// Testbench for ack_gated_send_queue_unit: random and directed write and acknowledge words,
// checked field by field against a behavioral copy of the ring, pointers and busy flag.
// Depends on agsq_pkg and ack_gated_send_queue_unit.
`timescale 1ns / 1ps

module ack_gated_send_queue_unit_tb;
    import agsq_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 200;
    localparam int STEADY_FROM = 320;
    localparam int STEADY_TO   = 390;
    localparam int FILL_WRITES = 258;
    localparam int MIXED_WORDS = 170;

    typedef struct packed {
        t_mode       mode;
        logic [3:0]  len;
        logic [63:0] bytes;
        logic        accepts;
        logic        wait_empty;
    } t_link_request;

    typedef struct packed {
        t_status     status;
        logic        sent;
        logic [3:0]  sent_len;
        logic [63:0] sent_bytes;
        t_timer      timer;
        logic        busy;
    } t_link_answer;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;

    t_link_request requests_todo[$];
    t_link_request offered;
    t_link_answer  answers_due[$];

    logic [63:0] ring_bytes[256];
    logic [3:0]  ring_len[256];
    logic [7:0]  ring_rd = '0;
    logic [7:0]  ring_wr = '0;
    logic        link_busy = 1'b0;

    int words_in   = 0;
    int words_total = 0;
    int mismatches = 0;
    int cycles     = 0;
    int hold_left  = 0;
    logic held_once = 1'b0;
    logic steady;

    assign steady = (words_in >= STEADY_FROM) && (words_in < STEADY_TO);

    ack_gated_send_queue_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic add_request(input t_mode mode, input logic [3:0] len,
                               input logic [63:0] bytes, input logic accepts,
                               input logic wait_empty);
        t_link_request r;
        r.mode       = mode;
        r.len        = len;
        r.bytes      = bytes;
        r.accepts    = accepts;
        r.wait_empty = wait_empty;
        requests_todo.push_back(r);
    endtask

    task automatic predict_link_answer(input t_link_request r);
        t_link_answer a;
        logic [63:0]  keep;
        logic [7:0]   nxt;
        a.status     = ST_OK;
        a.sent       = 1'b0;
        a.sent_len   = '0;
        a.sent_bytes = '0;
        a.timer      = TM_LEAVE;
        keep = (r.len >= 4'd8) ? {64{1'b1}} : ((64'd1 << (r.len * 8)) - 64'd1);
        if (r.mode == MODE_WRITE) begin
            if (r.len > MAX_BYTES_DEF) begin
                a.status = ST_TOO_LONG;
            end else if (link_busy) begin
                nxt = ring_wr + 8'd1;
                if (nxt == ring_rd) begin
                    a.status = ST_FULL;
                end else begin
                    ring_bytes[nxt] = r.bytes & keep;
                    ring_len[nxt]   = r.len;
                    ring_wr         = nxt;
                end
            end else if (r.accepts) begin
                link_busy    = 1'b1;
                a.sent       = 1'b1;
                a.sent_len   = r.len;
                a.sent_bytes = r.bytes & keep;
                a.timer      = TM_ARM;
            end else begin
                link_busy = 1'b0;
                a.timer   = TM_DISARM;
                a.status  = ST_FAILED;
            end
        end else begin
            if (!link_busy) begin
                a.status = ST_NOTHING;
            end else if (ring_rd == ring_wr) begin
                link_busy = 1'b0;
                a.timer   = TM_DISARM;
            end else if (r.accepts) begin
                nxt          = ring_rd + 8'd1;
                a.sent       = 1'b1;
                a.sent_len   = ring_len[nxt];
                a.sent_bytes = ring_bytes[nxt];
                ring_rd      = nxt;
            end else begin
                a.status = ST_FAILED;
                a.timer  = TM_ARM;
            end
        end
        a.busy = link_busy;
        answers_due.push_back(a);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40) begin
            $display("mismatch in %s at %0t: got %h, want %h", what, $realtime, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin : sender
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_link_answer(offered);
                words_in <= words_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (requests_todo.size() != 0
                        && !(requests_todo[0].wait_empty && answers_due.size() != 0)
                        && (steady || $urandom_range(99) >= 36)) begin
                    offered = requests_todo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, offered.accepts, offered.bytes, offered.len};
                    s_tuser  <= offered.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        t_link_answer want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("word with no result due", m_tdata[63:0], '0);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch("status", m_tdata[2:0], want.status);
                    if (m_tdata[3] !== want.sent)
                        report_mismatch("send_valid", m_tdata[3], want.sent);
                    if (m_tdata[7:4] !== want.sent_len)
                        report_mismatch("send_length", m_tdata[7:4], want.sent_len);
                    if (m_tdata[71:8] !== want.sent_bytes)
                        report_mismatch("send_data", m_tdata[71:8], want.sent_bytes);
                    if (m_tdata[73:72] !== want.timer)
                        report_mismatch("timer_action", m_tdata[73:72], want.timer);
                    if (m_tdata[74] !== want.busy)
                        report_mismatch("link_busy", m_tdata[74], want.busy);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!held_once && words_in >= HOLD_AT) begin
                hold_left <= HOLD_CYCLES;
                held_once <= 1'b1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int roll;
        // Directed words: every status but full, every timer action and the length extremes.
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd15, {$urandom, $urandom}, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd9,  {$urandom, $urandom}, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd8,  {64{1'b1}}, 1'b0, 1'b0);
        add_request(MODE_WRITE, 4'd0,  {$urandom, $urandom}, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd9,  {$urandom, $urandom}, 1'b0, 1'b0);
        add_request(MODE_WRITE, 4'd8,  {64{1'b1}}, 1'b0, 1'b0);
        add_request(MODE_WRITE, 4'd3,  {$urandom, $urandom}, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd1,  64'h0, 1'b1, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b0, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b1, 1'b0);
        add_request(MODE_ACK,   4'd15, {64{1'b1}}, 1'b1, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b0, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b1, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b0, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd5,  {$urandom, $urandom}, 1'b1, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b1, 1'b0);
        add_request(MODE_WRITE, 4'd8,  64'h0, 1'b1, 1'b0);
        add_request(MODE_ACK,   4'd0,  64'h0, 1'b1, 1'b0);
        // Fill the ring until it reports full; the sender first waits for all results.
        add_request(MODE_WRITE, 4'd8, {$urandom, $urandom}, 1'b1, 1'b1);
        for (int i = 0; i < FILL_WRITES; i++) begin
            add_request(MODE_WRITE, 4'($urandom_range(8)), {$urandom, $urandom},
                        1'($urandom), 1'b0);
        end
        // Mixed traffic: acknowledges and writes, some too long, against the filled ring.
        for (int i = 0; i < MIXED_WORDS; i++) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                add_request(MODE_ACK, 4'($urandom), {$urandom, $urandom},
                            $urandom_range(99) < 80, 1'b0);
            end else if (roll < 92) begin
                add_request(MODE_WRITE, 4'($urandom_range(8)), {$urandom, $urandom},
                            1'($urandom), 1'b0);
            end else begin
                add_request(MODE_WRITE, 4'($urandom_range(15, 9)), {$urandom, $urandom},
                            1'($urandom), 1'b0);
            end
        end
        words_total = requests_todo.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_in != words_total) @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
sv/agsq_pkg.sv
sv/ack_gated_send_queue_unit.sv
tb/ack_gated_send_queue_unit_tb.sv
